>>> rtl/three_stacks_shared_linked_pool_defines.svh
// ----------------------------------------------------------------------------
// Three stacks on a shared linked pool: assertion macros
// Short forms for the concurrent checks of the pool logic.
// ----------------------------------------------------------------------------
`ifndef THREE_STACKS_SHARED_LINKED_POOL_DEFINES_SVH
`define THREE_STACKS_SHARED_LINKED_POOL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tsslp_pkg.sv
// ----------------------------------------------------------------------------
// Three stacks on a shared linked pool: package
// Item types and operation and status codes shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsslp_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         stack_select;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic               now_empty;
        logic [1:0]         status;
    } t_out_item;

endpackage

>>> rtl/three_stacks_shared_linked_pool.sv
// ----------------------------------------------------------------------------
// Three stacks on a shared linked pool
// Several LIFO stacks whose nodes come from one common pool memory.
// ----------------------------------------------------------------------------
// In the cycle an item is accepted the pool memory is read at the head of the
// selected stack; then, in the execute state, the block finishes the operation,
// writes a pushed node and updates the head, and stalls new items until done.
// The pool is a single-port memory with a registered read. A result waits in
// the output register while the next item is being processed; only when that
// register is still full and the output is stalled at the end of an item does
// the block hold. Popped slots are never reused, so after POOL_DEPTH pushes
// every further push is refused. No clearing pass is run after reset.
`timescale 1ns / 1ps
`include "three_stacks_shared_linked_pool_defines.svh"

module three_stacks_shared_linked_pool #(
    parameter int POOL_DEPTH  = 1024,
    parameter int STACK_COUNT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tsslp_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tsslp_pkg::t_out_item  o_out_item
);
    import tsslp_pkg::*;

    localparam int ADDR_W = $clog2(POOL_DEPTH);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int SEL_W  = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

    localparam logic [PTR_W-1:0] NULL_PTR    = PTR_W'(POOL_DEPTH);
    localparam logic [4:0]       STACK_LIMIT = 5'(STACK_COUNT);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                r_state;
    logic                n_state;
    t_in_item            r_item;
    logic [PTR_W-1:0]    r_head [STACK_COUNT];
    logic [PTR_W-1:0]    r_free;
    logic [PTR_W-1:0]    n_free;

    logic signed [31:0]  r_node_value [POOL_DEPTH];
    logic [PTR_W-1:0]    r_node_link  [POOL_DEPTH];
    logic signed [31:0]  r_rd_value;
    logic [PTR_W-1:0]    r_rd_link;

    logic                r_out_valid;
    t_out_item           r_out_item;
    t_out_item           n_out_item;

    logic                in_accept;
    logic                done;
    logic [SEL_W-1:0]    in_idx;
    logic [SEL_W-1:0]    cur_idx;
    logic                cur_sel_ok;
    logic [PTR_W-1:0]    cur_head;
    logic                cur_head_ok;
    logic [PTR_W-1:0]    n_head;
    logic                head_we;
    logic                node_we;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign done        = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign in_idx      = SEL_W'(i_in_item.stack_select);
    assign cur_idx     = SEL_W'(r_item.stack_select);
    assign cur_sel_ok  = {3'b000, r_item.stack_select} < STACK_LIMIT;
    assign cur_head    = r_head[cur_idx];
    assign cur_head_ok = cur_head < NULL_PTR;

    always_comb begin
        n_state = r_state;
        if (in_accept) begin
            n_state = S_EXEC;
        end else if (done) begin
            n_state = S_IDLE;
        end
    end

    always_comb begin
        n_out_item            = '0;
        n_out_item.status     = ST_OK;
        n_out_item.now_empty  = 1'b1;
        n_head                = cur_head;
        n_free                = r_free;
        head_we               = 1'b0;
        node_we               = 1'b0;
        if (!cur_sel_ok) begin
            if (r_item.operation == OP_PUSH) begin
                n_out_item.status = ST_FULL;
            end else if (r_item.operation == OP_POP || r_item.operation == OP_PEEK) begin
                n_out_item.status = ST_EMPTY;
            end
        end else begin
            unique case (r_item.operation)
                OP_PUSH: begin
                    if (r_free >= NULL_PTR) begin
                        n_out_item.status = ST_FULL;
                    end else begin
                        node_we               = 1'b1;
                        head_we               = 1'b1;
                        n_head                = r_free;
                        n_free                = r_free + PTR_W'(1);
                        n_out_item.item_value = r_item.push_value;
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (!cur_head_ok) begin
                        n_out_item.status = ST_EMPTY;
                    end else begin
                        n_out_item.item_value = r_rd_value;
                        if (r_item.operation == OP_POP) begin
                            head_we = 1'b1;
                            n_head  = (r_rd_link < NULL_PTR) ? r_rd_link : NULL_PTR;
                        end
                    end
                end
                default: begin
                end
            endcase
            n_out_item.now_empty = !(n_head < NULL_PTR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < STACK_COUNT; i++) begin
                r_head[i] <= NULL_PTR;
            end
        end else begin
            r_state <= n_state;
            if (done) begin
                r_free      <= n_free;
                r_out_valid <= 1'b1;
                if (head_we) begin
                    r_head[cur_idx] <= n_head;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        if (done) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && node_we) begin
            r_node_value[r_free[ADDR_W-1:0]] <= r_item.push_value;
            r_node_link[r_free[ADDR_W-1:0]]  <= cur_head_ok ? cur_head : NULL_PTR;
        end
        if (in_accept) begin
            r_rd_value <= r_node_value[r_head[in_idx][ADDR_W-1:0]];
            r_rd_link  <= r_node_link[r_head[in_idx][ADDR_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `TSSLP_ASSERT_NEXT(a_accept_to_exec, in_accept, r_state == S_EXEC,
        "accepted item did not enter execution")
    `TSSLP_ASSERT_NOW(a_free_in_range, 1'b1, r_free <= NULL_PTR,
        "free slot counter ran past the pool")
    `TSSLP_ASSERT_NEXT(a_free_bump, r_state == S_EXEC,
        r_free == $past(r_free) || r_free == $past(r_free) + PTR_W'(1),
        "free slot counter moved by more than one")
    `TSSLP_ASSERT_NOW(a_empty_status, o_out_valid && o_out_item.status == ST_EMPTY,
        o_out_item.now_empty && o_out_item.item_value == 32'sd0,
        "empty status without empty flag or with a value")

endmodule
